@@ hdl/acpr_pkg.sv @@
// ----------------------------------------------------------------------------
// acpr_pkg
// Shared types and constants for the attribute cell pixel renderer.
// ----------------------------------------------------------------------------
package acpr_pkg;

  // picture geometry
  localparam int BMP_DEPTH     = 6144;
  localparam int ATTR_DEPTH    = 768;
  localparam int BMP_AW        = $clog2(BMP_DEPTH);
  localparam int ATTR_AW       = $clog2(ATTR_DEPTH);
  localparam int PICTURE_LINES = 192;
  localparam int LEFT_EDGE     = 32;

  // field widths
  localparam int LINE_W   = 8;
  localparam int COL_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int CLR_W    = 4;
  localparam int BORDER_W = 5;
  localparam int FLASH_W  = 5;
  localparam int PIX_CNT_W = 3;

  localparam int S_DATA_W = 32;  // line, column, pixel, attribute (29 bits used)
  localparam int M_DATA_W = 24;  // screen_x, screen_y, colour (21 bits used)

  // item kinds on s_tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CELL = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_REDRAW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_ROWS = 2'd1;
  localparam logic [BORDER_W-1:0]  BORDER_RESET    = 5'd4;

  // one cell handed to the pixel emitter
  typedef struct packed {
    logic [BYTE_W-1:0] pix;
    logic [CLR_W-1:0]  ink;
    logic [CLR_W-1:0]  paper;
    logic [COL_W-1:0]  column;
    logic [Y_W-1:0]    sy;
  } emit_cell_t;

endpackage

@@ hdl/acpr_ram.sv @@
// ----------------------------------------------------------------------------
// acpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/acpr_emit.sv @@
// ----------------------------------------------------------------------------
// acpr_emit
// Pixel emitter: streams the eight pixels of one cell, one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module acpr_emit
  import acpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  emit_cell_t          cell_in,
  input  logic                load,
  output logic                can_load,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // screen_x[8:0], screen_y[16:9], colour[20:17]
  output logic                m_tlast
);

  logic                 busy;
  logic [PIX_CNT_W-1:0] cnt;
  logic [BYTE_W-1:0]    pix;
  logic [CLR_W-1:0]     ink;
  logic [CLR_W-1:0]     paper;
  logic [COL_W-1:0]     column;
  logic [Y_W-1:0]       sy;
  logic                 at_last;
  logic [X_W-1:0]       sx;
  logic [CLR_W-1:0]     colour;

  assign at_last  = (cnt == {PIX_CNT_W{1'b1}});
  assign can_load = !busy || (m_tready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_tready) begin
      cnt <= cnt + 1'b1;
      if (at_last) begin
        busy <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      pix    <= cell_in.pix;
      ink    <= cell_in.ink;
      paper  <= cell_in.paper;
      column <= cell_in.column;
      sy     <= cell_in.sy;
    end else if (busy && m_tready) begin
      pix <= {pix[BYTE_W-2:0], 1'b0};
    end
  end

  assign sx       = X_W'(LEFT_EDGE) + X_W'({column, cnt});
  assign colour   = pix[BYTE_W-1] ? ink : paper;
  assign m_tvalid = busy;
  assign m_tlast  = at_last;
  assign m_tdata  = {{(M_DATA_W - X_W - Y_W - CLR_W){1'b0}}, colour, sy, sx};

`ifndef NO_ASSERTIONS
  // a cell finishes only after its eighth pixel was taken
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(m_tready) && $past(cnt) == {PIX_CNT_W{1'b1}})
    else $error("emitter dropped a cell early");

  // a new cell never overwrites one whose pixels are still pending
  assert property (@(posedge clk) disable iff (rst)
    load && busy |-> m_tready && at_last)
    else $error("emitter loaded over a pending cell");

  // the pixel counter moves only when an item leaves
  assert property (@(posedge clk) disable iff (rst)
    busy && !m_tready && !load |=> $stable(cnt))
    else $error("pixel counter moved under stall");
`endif

endmodule

@@ hdl/attribute_cell_pixel_renderer_unit.sv @@
// ----------------------------------------------------------------------------
// attribute_cell_pixel_renderer_unit
// Renders 8-pixel attribute cells into colour-indexed pixel items, with
// optional change detection against shadow copies of the picture memory.
// ----------------------------------------------------------------------------
// Path: a drawn cell is registered in stage 1, then loaded into the emitter,
//   which sends its pixels one pixel item a cycle while m_tready is high; frame
//   ticks, ignored and unchanged cells leave stage 1 without waiting.
// Reset: flash counter and config cleared (border rows 4), then a clearing
//   pass over every bitmap address zeroes both shadow RAMs; s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module attribute_cell_pixel_renderer_unit
  import acpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // cell / tick input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // line[7:0], column[12:8], pixel_byte[20:13],
                                          // attr_byte[28:21]
  input  logic                 s_tuser,   // req_type
  // pixel output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // screen_x[8:0], screen_y[16:9],
                                          // colour_index[20:17]
  output logic                 m_tlast,   // last_pixel
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BORDER_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                full_redraw;
  logic [BORDER_W-1:0] border_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_redraw <= 1'b0;
      border_rows <= BORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FULL_REDRAW: full_redraw <= cfg_data[0];
        CFG_BORDER_ROWS: border_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking and shadow addresses
  // --------------------------------------------------------------------------
  logic [LINE_W-1:0] in_line;
  logic [COL_W-1:0]  in_col;
  logic [BYTE_W-1:0] in_pix;
  logic [BYTE_W-1:0] in_attr;
  logic [BMP_AW-1:0]  in_baddr;
  logic [ATTR_AW-1:0] in_aaddr;
  logic               accept;

  assign in_line = s_tdata[LINE_W-1:0];
  assign in_col  = s_tdata[LINE_W +: COL_W];
  assign in_pix  = s_tdata[LINE_W+COL_W +: BYTE_W];
  assign in_attr = s_tdata[LINE_W+COL_W+BYTE_W +: BYTE_W];

  // interleaved bitmap layout: third, pixel row, char row, column
  assign in_baddr = {in_line[7:6], in_line[2:0], in_line[5:3], in_col};
  assign in_aaddr = {in_line[7:3], in_col};

  assign accept = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic              clearing;
  logic [BMP_AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == BMP_AW'(BMP_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: shadow compare, colour decode, write-back
  // --------------------------------------------------------------------------
  logic               p1_vld;
  logic               p1_cell;
  logic [LINE_W-1:0]  p1_line;
  logic [COL_W-1:0]   p1_col;
  logic [BYTE_W-1:0]  p1_pix;
  logic [BYTE_W-1:0]  p1_attr;
  logic [BMP_AW-1:0]  p1_baddr;
  logic [ATTR_AW-1:0] p1_aaddr;

  // forwarded write data when the previous cell wrote the entry being read
  logic              byp_b;
  logic              byp_a;
  logic [BYTE_W-1:0] byp_b_data;
  logic [BYTE_W-1:0] byp_a_data;

  logic [BYTE_W-1:0] b_rdata;
  logic [BYTE_W-1:0] a_rdata;
  logic [BYTE_W-1:0] b_old;
  logic [BYTE_W-1:0] a_old;
  logic              in_range;
  logic              changed;
  logic              p1_draw;
  logic              p1_go;
  logic              p1_bwr;
  logic              p1_awr;

  logic [FLASH_W-1:0] flash_count;
  logic               phase;
  logic [CLR_W-1:0]   attr_ink;
  logic [CLR_W-1:0]   attr_paper;
  emit_cell_t         emit_in;
  logic               emit_load;
  logic               emit_can_load;

  assign b_old    = byp_b ? byp_b_data : b_rdata;
  assign a_old    = byp_a ? byp_a_data : a_rdata;
  assign in_range = (p1_line < LINE_W'(PICTURE_LINES));
  assign changed  = (b_old != p1_pix) || (a_old != p1_attr);
  assign p1_draw  = p1_vld && (p1_cell == REQ_CELL) && in_range && (full_redraw || changed);

  // a drawing cell waits for the emitter; everything else passes without waiting
  assign p1_go     = !p1_draw || emit_can_load;
  assign emit_load = p1_draw && emit_can_load;

  // shadow write-back in diff mode; attribute only on the cell's bottom line
  assign p1_bwr = p1_vld && (p1_cell == REQ_CELL) && in_range && !full_redraw && changed &&
                  p1_go;
  assign p1_awr = p1_bwr && (p1_line[2:0] == 3'd7);

  assign s_tready = !clearing && (!p1_vld || p1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (s_tready) begin
      p1_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_cell    <= s_tuser;
      p1_line    <= in_line;
      p1_col     <= in_col;
      p1_pix     <= in_pix;
      p1_attr    <= in_attr;
      p1_baddr   <= in_baddr;
      p1_aaddr   <= in_aaddr;
      byp_b      <= p1_bwr && (p1_baddr == in_baddr);
      byp_a      <= p1_awr && (p1_aaddr == in_aaddr);
      byp_b_data <= p1_pix;
      byp_a_data <= p1_attr;
    end
  end

  // flash counter advances in stream order, as a tick leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_count <= '0;
    end else if (p1_vld && (p1_cell == REQ_TICK)) begin
      flash_count <= flash_count + 1'b1;
    end
  end

  // phase is on for the first half of the flash cycle
  assign phase      = !flash_count[FLASH_W-1];
  assign attr_ink   = {p1_attr[6], p1_attr[2:0]};
  assign attr_paper = p1_attr[6:3];

  always_comb begin
    emit_in.pix    = p1_pix;
    emit_in.column = p1_col;
    emit_in.sy     = p1_line + Y_W'(border_rows);
    if (p1_attr[7] && phase) begin
      emit_in.ink   = attr_paper;
      emit_in.paper = attr_ink;
    end else begin
      emit_in.ink   = attr_ink;
      emit_in.paper = attr_paper;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow memories
  // --------------------------------------------------------------------------
  logic               b_we;
  logic [BMP_AW-1:0]  b_waddr;
  logic [BYTE_W-1:0]  b_wdata;
  logic               a_we;
  logic [ATTR_AW-1:0] a_waddr;
  logic [BYTE_W-1:0]  a_wdata;

  assign b_we    = clearing || p1_bwr;
  assign b_waddr = clearing ? clr_cnt : p1_baddr;
  assign b_wdata = clearing ? '0 : p1_pix;
  assign a_we    = clearing ? (clr_cnt < BMP_AW'(ATTR_DEPTH)) : p1_awr;
  assign a_waddr = clearing ? clr_cnt[ATTR_AW-1:0] : p1_aaddr;
  assign a_wdata = clearing ? '0 : p1_attr;

  acpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BMP_DEPTH)
  ) u_bitmap_shadow (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (in_baddr),
    .rdata (b_rdata)
  );

  acpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ATTR_DEPTH)
  ) u_attr_shadow (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (accept),
    .raddr (in_aaddr),
    .rdata (a_rdata)
  );

  // --------------------------------------------------------------------------
  // Pixel emitter
  // --------------------------------------------------------------------------
  acpr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .cell_in  (emit_in),
    .load     (emit_load),
    .can_load (emit_can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // nothing drawn or written back while the shadows are being cleared
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_tvalid && !p1_bwr && !p1_vld)
    else $error("activity during clearing pass");

  // the flash counter only moves for a frame tick in stage 1
  assert property (@(posedge clk) disable iff (rst)
    !$stable(flash_count) |-> $past(p1_vld) && ($past(p1_cell) == REQ_TICK))
    else $error("flash counter moved without a tick");

  // forwarding is armed only by a write that happened with the accept
  assert property (@(posedge clk) disable iff (rst)
    accept && !(p1_bwr && (p1_baddr == in_baddr)) |=> !byp_b)
    else $error("stale bitmap forward");

  // attribute write-back always comes with a bitmap write-back
  assert property (@(posedge clk) disable iff (rst)
    p1_awr |-> p1_bwr && !clearing && (p1_line[2:0] == 3'd7))
    else $error("attribute shadow written out of turn");
`endif

endmodule

@@ bench/acpr_pixel_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acpr_pixel_checker
// Watches the cell, pixel and register channels of the renderer. It keeps its
// own shadow stores, flash counter and register copies, predicts the pixels of
// every accepted cell and compares each accepted pixel item in order.
// ----------------------------------------------------------------------------
module acpr_pixel_checker
  import acpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BORDER_W-1:0]  cfg_data,
  output int unsigned          pending_pixels,
  output int unsigned          fail_count
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [X_W-1:0]   sx;
    logic [Y_W-1:0]   sy;
    logic [CLR_W-1:0] colour;
    logic             last;
  } pixel_t;

  pixel_t              pixel_q[$];
  logic [BYTE_W-1:0]   bmp_shadow  [BMP_DEPTH];
  logic [BYTE_W-1:0]   attr_shadow [ATTR_DEPTH];
  logic [FLASH_W-1:0]  flash_cnt;
  logic                full_mode;
  logic [BORDER_W-1:0] border;

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    if (fail_count < MAX_REPORTS)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  // expected pixels of one cell, with the shadow update of diff mode
  task automatic draw_cell(input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
                           input logic [BYTE_W-1:0] pix, input logic [BYTE_W-1:0] attr);
    logic [BMP_AW-1:0]  ba;
    logic [ATTR_AW-1:0] aa;
    logic [CLR_W-1:0]   ink;
    logic [CLR_W-1:0]   paper;
    logic [CLR_W-1:0]   swap;
    pixel_t             px;
    if (ln >= PICTURE_LINES) return;
    ba = {ln[7:6], ln[2:0], ln[5:3], col};   // interleaved bitmap layout
    aa = {ln[7:3], col};
    if (!full_mode) begin
      if (bmp_shadow[ba] == pix && attr_shadow[aa] == attr) return;
      bmp_shadow[ba] = pix;
      if (ln[2:0] == 3'd7) attr_shadow[aa] = attr;
    end
    ink   = {attr[6], attr[2:0]};
    paper = attr[6:3];
    if (attr[7] && !flash_cnt[4]) begin
      swap  = ink;
      ink   = paper;
      paper = swap;
    end
    for (int k = 0; k < 8; k++) begin
      px.sx     = X_W'(LEFT_EDGE) + {1'b0, col, 3'(k)};
      px.sy     = ln + Y_W'(border);
      px.colour = pix[7-k] ? ink : paper;
      px.last   = (k == 7);
      pixel_q.push_back(px);
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst) begin
      foreach (bmp_shadow[i]) bmp_shadow[i] = '0;
      foreach (attr_shadow[i]) attr_shadow[i] = '0;
      flash_cnt = '0;
      full_mode = 1'b0;
      border    = BORDER_RESET;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FULL_REDRAW) full_mode = cfg_data[0];
        else if (cfg_index == CFG_BORDER_ROWS) border = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_TICK) flash_cnt = flash_cnt + 1'b1;
        else draw_cell(s_tdata[7:0], s_tdata[12:8], s_tdata[20:13], s_tdata[28:21]);
      end
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected pixel, screen_x", 0, m_tdata[X_W-1:0]);
        end else begin
          want = pixel_q.pop_front();
          if (m_tdata[X_W-1:0] != want.sx)
            report("screen_x", want.sx, m_tdata[X_W-1:0]);
          if (m_tdata[X_W+Y_W-1:X_W] != want.sy)
            report("screen_y", want.sy, m_tdata[X_W+Y_W-1:X_W]);
          if (m_tdata[X_W+Y_W+CLR_W-1:X_W+Y_W] != want.colour)
            report("colour_index", want.colour, m_tdata[X_W+Y_W+CLR_W-1:X_W+Y_W]);
          if (m_tlast !== want.last)
            report("last_pixel", want.last, m_tlast);
        end
      end
    end
    pending_pixels <= pixel_q.size();
  end

endmodule

@@ bench/attribute_cell_pixel_renderer_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attribute_cell_pixel_renderer_unit_test
// Drives frame ticks and display cells into the renderer with random gaps and
// output stalls, under several register settings, and lets the checker beside
// the block predict and compare every pixel item.
// ----------------------------------------------------------------------------
module attribute_cell_pixel_renderer_unit_test;
  import acpr_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 70;    // about 460 items in all with the directed part
  localparam int RX_HOLD      = 300;   // long output hold-off, in cycles
  localparam int SETTLE_TICKS = 12;    // unchanged cells may still be in flight

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata   = '0;
  logic                 s_tuser   = REQ_TICK;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FULL_REDRAW;
  logic [BORDER_W-1:0]  cfg_data  = '0;

  int unsigned pending_pixels;
  int unsigned fail_count;

  // stall controls for the cell sender and the pixel receiver
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_rx = 1'b0;

  always #1 clk = ~clk;

  attribute_cell_pixel_renderer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  acpr_pixel_checker i_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending_pixels (pending_pixels),
    .fail_count     (fail_count)
  );

  // Offer one item and hold it until the block takes it. tvalid is left high
  // so that a back-to-back item needs no second assignment in the same step.
  task automatic offer(input logic kind, input logic [7:0] ln, input logic [4:0] col,
                       input logic [7:0] pix, input logic [7:0] attr);
    s_tuser  <= kind;
    s_tdata  <= {3'b000, attr, pix, col, ln};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Gap after an item: mostly none, sometimes short, now and then long.
  task automatic tx_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 9);
    if (tx_calm || r < 6) n = 0;
    else if (r < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 30);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic push_cell(input logic [7:0] ln, input logic [4:0] col,
                           input logic [7:0] pix, input logic [7:0] attr);
    offer(REQ_CELL, ln, col, pix, attr);
    tx_gap();
  endtask

  // frame tick; the cell fields ride along as noise
  task automatic push_tick();
    offer(REQ_TICK, 8'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
    tx_gap();
  endtask

  // Stop sending and wait until every predicted pixel has come out, then let
  // a cell that may produce nothing pass through the block as well.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_pixels == 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BORDER_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel receiver: random stalls, a one-off long hold-off on request, and
  // stall-free stretches when rx_calm is set.
  initial begin : pixel_sink
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        hold_rx = 1'b0;
        m_tready <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit: clearing pass, a long hold-off and worst-case stalls on every
  // pixel still fit several times over.
  initial begin : watchdog
    #2000000;
    $display("FAIL attribute_cell_pixel_renderer_unit");
    $finish;
  end

  initial begin : stimulus
    int unsigned       done;
    int unsigned       r;
    int unsigned       reps;
    bit                paused;
    logic [4:0]        grp;
    logic [4:0]        col;
    logic [7:0]        attr;
    logic [7:0]        ln;
    logic [7:0]        rows [8];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, reset settings: diff mode, border of 4 rows ---
    push_cell(8'd0,   5'd0,  8'h00, 8'h00);   // matches cleared shadows: no pixels
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF);   // last cell, bright, flashing with phase on
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF);   // eighth line stored the attribute: unchanged
    push_cell(8'd100, 5'd17, 8'hA5, 8'h47);
    push_cell(8'd100, 5'd17, 8'hA5, 8'h47);   // attribute not stored off line 7: drawn again
    push_cell(8'd192, 5'd0,  8'hFF, 8'hFF);   // below the picture: ignored
    push_cell(8'd255, 5'd31, 8'h5A, 8'hC3);
    push_tick();
    push_cell(8'd63,  5'd8,  8'h81, 8'h80);   // flash set, colours zero
    push_cell(8'd135, 5'd3,  8'h3C, 8'h3F);   // no bright, no flash
    settle();

    // full redraw, widest border the bench uses: shadows left alone, screen_y at its top
    write_reg(CFG_FULL_REDRAW, 5'd1);
    write_reg(CFG_BORDER_ROWS, 5'd24);
    push_cell(8'd0,   5'd0,  8'h00, 8'h00);
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF);
    push_cell(8'd71,  5'd12, 8'h0F, 8'h7E);
    push_tick();
    settle();

    // back to diff mode, no border: shadows must be as diff mode left them
    write_reg(CFG_FULL_REDRAW, 5'd0);
    write_reg(CFG_BORDER_ROWS, 5'd0);
    push_cell(8'd191, 5'd31, 8'hFF, 8'hFF);   // unchanged
    push_cell(8'd71,  5'd12, 8'h0F, 8'h7E);   // full mode did not store it: drawn
    push_cell(8'd0,   5'd31, 8'h01, 8'hB8);
    settle();

    // --- random part, one register setting per phase ---
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_FULL_REDRAW, 5'(p % 2));
      write_reg(CFG_BORDER_ROWS, (p == 0) ? 5'd24 : (p == 1) ? 5'd0
                                          : 5'($urandom_range(0, 24)));
      tx_calm = (p == 2);
      rx_calm = (p == 2);
      // receiver holds off while cells keep coming, so the block backs up
      if (p == 3) hold_rx = 1'b1;
      paused = 1'b0;
      done   = 0;
      while (done < PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          push_tick();
          done++;
        end else if (r < 3) begin
          push_cell(8'($urandom_range(192, 255)), 5'($urandom), 8'($urandom), 8'($urandom));
          done++;
        end else if (r < 14) begin
          // one character cell, eight lines with one attribute, often sent twice
          grp  = 5'($urandom_range(0, 23));
          col  = 5'($urandom);
          attr = 8'($urandom);
          foreach (rows[i]) rows[i] = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
          reps = $urandom_range(1, 2);
          for (int rep = 0; rep < reps; rep++) begin
            if (rep > 0 && $urandom_range(0, 3) == 0) rows[$urandom_range(0, 7)] ^= 8'h10;
            for (int i = 0; i < 8; i++) begin
              push_cell({grp, 3'(i)}, col, rows[i], attr);
              done++;
            end
          end
        end else begin
          ln   = 8'($urandom_range(0, 191));
          attr = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
          push_cell(ln, 5'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), attr);
          done++;
        end
        // sender stops mid-phase until the block has drained
        if (p == 4 && !paused && done >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          settle();
        end
      end
      settle();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_pixels == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("PASS attribute_cell_pixel_renderer_unit");
    end else begin
      $display("FAIL attribute_cell_pixel_renderer_unit");
    end
    $finish;
  end

endmodule
